### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent assertions of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/flpw_pkg.sv
// ----------------------------------------------------------------------------
// flpw_pkg
// Types and constants shared by the page walker and its table memory.
// ----------------------------------------------------------------------------
package flpw_pkg;

  localparam int ENTRY_W = 48;
  localparam int CHILD_W = 6;
  localparam int IDX_W   = 9;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  localparam logic [ENTRY_W-1:0] BASE_1G = 48'hFFFF_C000_0000;
  localparam logic [ENTRY_W-1:0] BASE_2M = 48'hFFFF_FFE0_0000;
  localparam logic [ENTRY_W-1:0] BASE_4K = 48'hFFFF_FFFF_F000;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // One stored slot: the entry and the number of the table it points to.
  typedef struct packed {
    logic [CHILD_W-1:0] child;
    logic [ENTRY_W-1:0] entry;
  } slot_t;

endpackage

### hw/rtl/flpw_mem.sv
// ----------------------------------------------------------------------------
// flpw_mem
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
module flpw_mem
  import flpw_pkg::*;
#(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data
);

  slot_t mem [0:DEPTH-1];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/four_level_page_walk_top.sv
// ----------------------------------------------------------------------------
// four_level_page_walk_top
// Four-level radix page table walker over an on-chip table memory.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low.
// A write transaction (in_operation = 0) stores one entry and its child table
// number at the accepting edge and produces no result; busy stays low, so
// another transaction may follow in the next cycle. A write to a table at or
// above TABLE_COUNT is dropped.
// A translate transaction (in_operation = 1) walks from root table 0 using
// the four 9-bit index fields of in_virtual_address. The first level read is
// issued at the accepting edge; each level then checks its registered read
// data and either ends the walk or issues the next read, so the result is
// registered once the level where the walk stops has been checked, from the
// first level for a walk that stops there to the fourth for a full 4K walk.
// The levels depend on each other through the child number, which sets the
// rate. busy is high while the walk runs.
// The result appears on out_physical_base and out_mapped for exactly one
// cycle with out_valid high, in the same cycle that busy falls, and the next
// transaction may be accepted at the edge that ends it. The receiver cannot
// stall; it must take the result in that cycle.
// Synchronous reset clears the control state only; table contents are
// undefined until written, so no clearing pass is made.
// ----------------------------------------------------------------------------
module four_level_page_walk_top
  import flpw_pkg::*;
#(
  parameter int TABLE_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [5:0]          in_table_number,
  input  logic [IDX_W-1:0]    in_entry_number,
  input  logic [63:0]         in_entry_word,
  input  logic [CHILD_W-1:0]  in_child_number,
  input  logic [47:0]         in_virtual_address,
  output logic                out_valid,
  output logic [ENTRY_W-1:0]  out_physical_base,
  output logic                out_mapped
);

`include "assert_macros.svh"

  // Table number width and memory geometry follow from the table count.
  localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int AW    = TW + IDX_W;
  localparam int DEPTH = TABLE_COUNT * 512;
  localparam logic [12:0] TABLE_LIMIT = 13'(TABLE_COUNT);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  localparam logic [1:0] LVL_1 = 2'd0;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_4 = 2'd3;

  // Memory address of one entry: table number above the 9-bit index.
  function automatic logic [AW-1:0] slot_addr(input logic [5:0] tbl,
                                              input logic [IDX_W-1:0] idx);
    logic [11:0] tbl12;
    tbl12 = {6'b0, tbl};
    return {tbl12[TW-1:0], idx};
  endfunction

  function automatic logic table_ok(input logic [5:0] tbl);
    return {7'b0, tbl} < TABLE_LIMIT;
  endfunction

  logic               state_r, state_nxt;
  logic [1:0]         lvl_r, lvl_nxt;
  logic [47:0]        va_r, va_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0] out_base_r, out_base_nxt;
  logic               out_mapped_r, out_mapped_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  slot_t         wr_data, rd_data;
  logic [IDX_W-1:0] idx_next;

  flpw_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Index into the table of the level after the one being checked.
  always_comb begin
    case (lvl_r)
      LVL_1:   idx_next = va_r[38:30];
      LVL_2:   idx_next = va_r[29:21];
      default: idx_next = va_r[20:12];
    endcase
  end

  // Writes complete at acceptance and a walk's first read is issued at a later
  // accepting edge, so a read never meets a write in flight.
  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    va_nxt         = va_r;
    out_valid_nxt  = 1'b0;
    out_base_nxt   = out_base_r;
    out_mapped_nxt = out_mapped_r;
    wr_en          = 1'b0;
    wr_addr        = slot_addr(in_table_number, in_entry_number);
    wr_data.entry  = in_entry_word[ENTRY_W-1:0];
    wr_data.child  = in_child_number;
    rd_en          = 1'b0;
    rd_addr        = slot_addr(6'd0, in_virtual_address[47:39]);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_WRITE) begin
            wr_en = table_ok(in_table_number);
          end else begin
            rd_en     = 1'b1;
            va_nxt    = in_virtual_address;
            lvl_nxt   = LVL_1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!rd_data.entry[BIT_PRESENT]) begin
          out_valid_nxt  = 1'b1;
          out_base_nxt   = '0;
          out_mapped_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else if (lvl_r == LVL_2 && rd_data.entry[BIT_LARGE]) begin
          out_valid_nxt  = 1'b1;
          out_base_nxt   = rd_data.entry & BASE_1G;
          out_mapped_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (lvl_r == LVL_3 && rd_data.entry[BIT_LARGE]) begin
          out_valid_nxt  = 1'b1;
          out_base_nxt   = rd_data.entry & BASE_2M;
          out_mapped_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (lvl_r == LVL_4) begin
          out_valid_nxt  = 1'b1;
          out_base_nxt   = rd_data.entry & BASE_4K;
          out_mapped_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (!table_ok(rd_data.child)) begin
          // A child table beyond the store reads as an empty entry.
          out_valid_nxt  = 1'b1;
          out_base_nxt   = '0;
          out_mapped_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(rd_data.child, idx_next);
          lvl_nxt = lvl_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= LVL_1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r         <= va_nxt;
    out_base_r   <= out_base_nxt;
    out_mapped_r <= out_mapped_nxt;
  end

  assign busy              = (state_r == ST_WALK);
  assign out_valid         = out_valid_r;
  assign out_physical_base = out_base_r;
  assign out_mapped        = out_mapped_r;

  `ASSERT_NEXT(a_write_no_result, clk, rst_n, start && !busy && in_operation == OP_WRITE, !out_valid, "write transaction produced a result")
  `ASSERT_IMPLIES(a_result_when_idle, clk, rst_n, out_valid, !busy, "result shown while walk still running")
  `ASSERT_NEXT(a_walk_bounded, clk, rst_n, busy && lvl_r == LVL_4, !busy && out_valid, "walk ran past the fourth level")
  `ASSERT_IMPLIES(a_unmapped_zero, clk, rst_n, out_valid && !out_mapped, out_physical_base == '0, "unmapped result with nonzero base")

endmodule

### sim/tb_four_level_page_walk.sv
// ----------------------------------------------------------------------------
// Four-level page walker testbench
// Drives table entry writes and address translations into the walker and
// checks every translation result against a known result or an in-bench table model.
// ----------------------------------------------------------------------------
module testbench
  import flpw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The walker is built with its default table count; the bench mirrors it.
  localparam int TABLE_COUNT  = 64;
  localparam int SLOT_COUNT   = TABLE_COUNT * 512;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;
  // The settle time at the end outlasts a full 4K walk.
  localparam int SETTLE_CYCLES = 8;
  localparam int DIRECTED_ROWS = 24;

  // One request as it is placed on the in_ ports.
  typedef struct {
    logic               op;
    logic [5:0]         tbl;
    logic [IDX_W-1:0]   entry;
    logic [63:0]        word;
    logic [CHILD_W-1:0] child;
    logic [47:0]        va;
  } walk_request_t;

  // One translation result as it is expected on the out_ ports.
  typedef struct packed {
    logic [ENTRY_W-1:0] base;
    logic               mapped;
  } walk_result_t;

  // A row of the directed table. Where known is set, the row carries a
  // result that is obvious from the entries written so far; every other
  // translation is checked against the table model.
  typedef struct {
    logic               op;
    logic [5:0]         tbl;
    logic [IDX_W-1:0]   entry;
    logic [63:0]        word;
    logic [CHILD_W-1:0] child;
    logic [47:0]        va;
    bit                 known;
    logic [ENTRY_W-1:0] known_base;
    logic               known_mapped;
  } directed_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_operation;
  logic [5:0]         in_table_number;
  logic [IDX_W-1:0]   in_entry_number;
  logic [63:0]        in_entry_word;
  logic [CHILD_W-1:0] in_child_number;
  logic [47:0]        in_virtual_address;
  logic               out_valid;
  logic [ENTRY_W-1:0] out_physical_base;
  logic               out_mapped;

  // Table model: the entry and child number of every slot, plus a record of
  // which slots have been written. The walker's memory is undefined until a
  // slot is written, so translations are only ever steered through written
  // slots. written_list keeps the written entry numbers of each table.
  logic [ENTRY_W-1:0] model_entry [0:SLOT_COUNT-1];
  logic [CHILD_W-1:0] model_child [0:SLOT_COUNT-1];
  bit                 slot_written [0:SLOT_COUNT-1];
  logic [IDX_W-1:0]   written_list [0:TABLE_COUNT-1][0:511];
  int                 written_cnt [0:TABLE_COUNT-1];

  // Translation results that have been predicted but not yet seen.
  walk_result_t pending_walks[$];

  int mismatch_count;
  int cycle_count;
  bit idling_on;

  // The directed table builds one branch of the tree under root entry 511
  // and walks it to each kind of ending. Root entry 511 and table 1 entry
  // 511 are all ones, so the large page bit at the first level is shown to
  // be ignored and the 1G base takes its widest value. Unused fields are
  // loaded with ones on some rows to show that they are ignored.
  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // A root entry that is not present, then a walk that stops on it.
    '{OP_WRITE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd63, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 48'h0,
      1'b1, 48'h0, 1'b0},
    // All-ones entries: 1G page at the second level, upper word bits dropped.
    '{OP_WRITE, 6'd0, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, 6'd1, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_WRITE, 6'd1, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFFFF_FFFF_FFFF,
      1'b1, 48'hFFFF_C000_0000, 1'b1},
    // 2M page at the third level.
    '{OP_WRITE, 6'd1, 9'd0, 64'h1, 6'd2, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_WRITE, 6'd2, 9'd0, 64'h0000_1234_5660_0081, 6'd0, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_001F_FFFF, 1'b0, 48'h0, 1'b0},
    // Full 4K walk; the large page bit at the last level is ignored.
    '{OP_WRITE, 6'd2, 9'd1, 64'h1, 6'd3, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_WRITE, 6'd3, 9'd2, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd63, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 48'hFF80_0020_2FFF,
      1'b1, 48'hFFFF_FFFF_F000, 1'b1},
    // Not present at the third level, with every other bit set.
    '{OP_WRITE, 6'd2, 9'd2, 64'hFFFF_FFFF_FFFF_FFFE, 6'd5, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_0040_0000, 1'b1, 48'h0, 1'b0},
    // Not present at the last level.
    '{OP_WRITE, 6'd3, 9'd3, 64'hFFFF_FFFF_FFFF_F000, 6'd0, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_0020_3000, 1'b1, 48'h0, 1'b0},
    // Not present at the second level.
    '{OP_WRITE, 6'd1, 9'd1, 64'h0, 6'd0, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_4000_0000, 1'b1, 48'h0, 1'b0},
    // A mapped 1G page whose base is zero.
    '{OP_WRITE, 6'd1, 9'd2, 64'h81, 6'd63, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_8000_0000, 1'b1, 48'h0, 1'b1},
    // A 4K walk that passes through the highest table.
    '{OP_WRITE, 6'd2, 9'd3, 64'h1, 6'd63, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_WRITE, 6'd63, 9'd0, 64'h0000_ABCD_EF01_2345, 6'd63, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_0060_0000, 1'b0, 48'h0, 1'b0},
    // 1G page with an ordinary address and junk in the dropped upper bits.
    '{OP_WRITE, 6'd1, 9'd3, 64'h8000_7FFF_C0AB_CDEF, 6'd7, 48'h0, 1'b0, 48'h0, 1'b0},
    '{OP_TRANSLATE, 6'd0, 9'd0, 64'h0, 6'd0, 48'hFF80_FFFF_FFFF, 1'b0, 48'h0, 1'b0}
  };

  four_level_page_walk_top #(
    .TABLE_COUNT(TABLE_COUNT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_table_number    (in_table_number),
    .in_entry_number    (in_entry_number),
    .in_entry_word      (in_entry_word),
    .in_child_number    (in_child_number),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_physical_base  (out_physical_base),
    .out_mapped         (out_mapped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every mismatch is printed on one line and counted; the run carries on.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Applies an accepted write to the table model. Writes to a table beyond
  // the table count are dropped, as the walker drops them.
  function automatic void record_write(input logic [5:0] tbl, input logic [IDX_W-1:0] idx,
                                       input logic [63:0] word,
                                       input logic [CHILD_W-1:0] child);
    int slot;
    if (tbl < TABLE_COUNT) begin
      slot = {tbl, idx};
      model_entry[slot] = word[ENTRY_W-1:0];
      model_child[slot] = child;
      if (!slot_written[slot]) begin
        slot_written[slot] = 1'b1;
        written_list[tbl][written_cnt[tbl]] = idx;
        written_cnt[tbl]++;
      end
    end
  endfunction

  // Walks the table model from root table 0 and returns the page base that
  // the walker must report. A table beyond the table count reads as an
  // empty entry, which ends the walk unmapped.
  function automatic walk_result_t predict_walk(input logic [47:0] va);
    walk_result_t r;
    logic [5:0] tbl;
    logic [IDX_W-1:0] idx;
    logic [ENTRY_W-1:0] e;
    bit done;
    r = '0;
    tbl = '0;
    done = 1'b0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (!done) begin
        idx = va[47-9*lvl -: 9];
        e = (tbl < TABLE_COUNT) ? model_entry[{tbl, idx}] : '0;
        if (!e[BIT_PRESENT]) begin
          done = 1'b1;
        end else if (lvl == 1 && e[BIT_LARGE]) begin
          r.base = e & BASE_1G;
          r.mapped = 1'b1;
          done = 1'b1;
        end else if (lvl == 2 && e[BIT_LARGE]) begin
          r.base = e & BASE_2M;
          r.mapped = 1'b1;
          done = 1'b1;
        end else if (lvl == 3) begin
          r.base = e & BASE_4K;
          r.mapped = 1'b1;
          done = 1'b1;
        end else begin
          tbl = model_child[{tbl, idx}];
        end
      end
    end
    return r;
  endfunction

  // Picks a virtual address whose walk reads only written slots. At each
  // level an index is drawn from the written entries of the current table;
  // the index bits below the level where the walk ends stay random. If the
  // walk reaches a table with nothing written, the function returns 0 and
  // names the slot that has to be written first.
  function automatic bit plan_walk(output logic [47:0] va, output logic [5:0] stuck_tbl,
                                   output logic [IDX_W-1:0] stuck_idx);
    logic [5:0] tbl;
    logic [IDX_W-1:0] idx;
    logic [ENTRY_W-1:0] e;
    va = {16'($urandom), 32'($urandom)};
    tbl = '0;
    stuck_tbl = '0;
    stuck_idx = '0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (written_cnt[tbl] == 0) begin
        stuck_tbl = tbl;
        stuck_idx = va[47-9*lvl -: 9];
        return 1'b0;
      end
      idx = written_list[tbl][$urandom_range(written_cnt[tbl] - 1)];
      va[47-9*lvl -: 9] = idx;
      e = model_entry[{tbl, idx}];
      if (!e[BIT_PRESENT] || lvl == 3 || ((lvl == 1 || lvl == 2) && e[BIT_LARGE]))
        return 1'b1;
      tbl = model_child[{tbl, idx}];
    end
    return 1'b1;
  endfunction

  // A request with every field random. Entries are mostly present and carry
  // the large page bit half the time; child numbers favor the low tables so
  // that the tree grows deep instead of wide.
  function automatic walk_request_t random_request();
    walk_request_t req;
    req.op = $urandom_range(1) ? OP_TRANSLATE : OP_WRITE;
    req.tbl = 6'($urandom_range(63));
    req.entry = 9'($urandom_range(511));
    req.word = {$urandom, $urandom};
    req.word[BIT_PRESENT] = ($urandom_range(99) < 85);
    req.word[BIT_LARGE] = $urandom_range(1);
    req.child = ($urandom_range(99) < 80) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    req.va = {16'($urandom), 32'($urandom)};
    return req;
  endfunction

  // Places one transaction on the input ports and holds it until the walker
  // takes it. The sender idles at random beforehand. start is not lowered
  // after acceptance: the next call either idles or raises it for the next
  // transaction, so start gets only one assignment per edge.
  task automatic issue_request(input walk_request_t req, input bit known,
                               input walk_result_t known_result);
    while (idling_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_operation       <= req.op;
    in_table_number    <= req.tbl;
    in_entry_number    <= req.entry;
    in_entry_word      <= req.word;
    in_child_number    <= req.child;
    in_virtual_address <= req.va;
    // busy is read before the edge's updates land, so it is the value that
    // decided acceptance at this edge.
    do @(posedge clk); while (busy !== 1'b0);
    if (req.op == OP_WRITE)
      record_write(req.tbl, req.entry, req.word, req.child);
    else if (known)
      pending_walks.push_back(known_result);
    else
      pending_walks.push_back(predict_walk(req.va));
  endtask

  // Stops sending and waits for every outstanding translation to return.
  // The loop always waits for an edge first, so start never sees two assignments at once.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_walks.size() != 0);
  endtask

  // Results cannot be held off, so each one is checked at the edge that ends
  // its cycle against the oldest outstanding translation.
  always @(posedge clk) begin : check_results
    walk_result_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_walks.size() == 0) begin
        report_mismatch($sformatf("result base %h mapped %b with no translation outstanding",
                                  out_physical_base, out_mapped));
      end else begin
        want = pending_walks.pop_front();
        if (out_physical_base !== want.base)
          report_mismatch($sformatf("physical_base %h, expected %h",
                                    out_physical_base, want.base));
        if (out_mapped !== want.mapped)
          report_mismatch($sformatf("mapped %b, expected %b", out_mapped, want.mapped));
      end
    end
  end

  // Watchdog: a hang or a lost result ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", pending_walks.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    walk_request_t req;
    walk_result_t known_result;
    logic [47:0] va;
    logic [5:0] stuck_tbl;
    logic [IDX_W-1:0] stuck_idx;

    mismatch_count = 0;
    cycle_count = 0;
    idling_on = 1'b1;
    for (int t = 0; t < TABLE_COUNT; t++)
      written_cnt[t] = 0;
    for (int s = 0; s < SLOT_COUNT; s++)
      slot_written[s] = 1'b0;

    // All inputs are known from time zero; reset is asserted at time zero
    // and never asserted again.
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_operation       <= OP_WRITE;
    in_table_number    <= '0;
    in_entry_number    <= '0;
    in_entry_word      <= '0;
    in_child_number    <= '0;
    in_virtual_address <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table row by row.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      req.op    = directed_rows[i].op;
      req.tbl   = directed_rows[i].tbl;
      req.entry = directed_rows[i].entry;
      req.word  = directed_rows[i].word;
      req.child = directed_rows[i].child;
      req.va    = directed_rows[i].va;
      known_result.base   = directed_rows[i].known_base;
      known_result.mapped = directed_rows[i].known_mapped;
      issue_request(req, directed_rows[i].known, known_result);
    end

    // Let the pipeline empty completely before the random part starts.
    wait_for_results();

    // Random part. Every translation follows a written path so that walks go
    // deep; a walk that runs into an empty table first writes the slot it
    // needs. The rest are writes anywhere, including overwrites of slots
    // that walks already use. Items 250 to 399 are sent back to back, and
    // the sender drains the walker now and then.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling_on = !(n >= 250 && n < 400);
      if (n % 150 == 149)
        wait_for_results();
      req = random_request();
      if ($urandom_range(99) < 40) begin
        req.op = OP_WRITE;
        if ($urandom_range(99) < 70)
          req.tbl = 6'($urandom_range(7));
        if (written_cnt[req.tbl] != 0 && $urandom_range(1))
          req.entry = written_list[req.tbl][$urandom_range(written_cnt[req.tbl] - 1)];
      end else if (plan_walk(va, stuck_tbl, stuck_idx)) begin
        req.op = OP_TRANSLATE;
        req.va = va;
      end else begin
        req.op = OP_WRITE;
        req.tbl = stuck_tbl;
        req.entry = stuck_idx;
      end
      issue_request(req, 1'b0, '0);
    end

    // Wait for the last results, then for the settle time to catch any stray
    // result strobe.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
